/* rtl/core/kf_pkg.sv */
package kf_pkg;

    // Serial arithmetic unit operations
    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    // Request into the serial unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_ureq;

    // Status back from the serial unit
    typedef struct packed {
        logic done;
        logic clip;
    } t_uresp;

    // Configuration register indexes
    localparam logic [2:0] REG_MEAS_NOISE  = 3'd0;
    localparam logic [2:0] REG_PROC_POS    = 3'd1;
    localparam logic [2:0] REG_PROC_CROSS  = 3'd2;
    localparam logic [2:0] REG_PROC_VEL    = 3'd3;
    localparam logic [2:0] REG_DRIVE_POS   = 3'd4;
    localparam logic [2:0] REG_DRIVE_VEL   = 3'd5;
    localparam logic [2:0] REG_INIT_VAR    = 3'd6;

    // Register reset values
    localparam logic [30:0] MEAS_NOISE_RST = 31'd65536;
    localparam logic [30:0] INIT_VAR_RST   = 31'd65536000;

endpackage

/* rtl/core/kalman_filter_pos_vel_1d_top.sv */
// Two-state (position, velocity) constant-velocity Kalman filter, signed fixed point.
// Input channel: one position measurement per transaction (i_in_valid / o_in_stall).
// Output channel: one result per input transaction (o_out_valid / i_out_stall) with
// updated state, predicted state, predicted covariance and a saturation flag.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data, to be written only while idle;
// the user must keep to this, the block does not enforce it. Writing init_var
// restarts the filter: state cleared, diagonal covariance reloaded.
// Each measurement runs two gain divisions and five multiplies through the
// bit-serial unit, then the predict step; when P00+R is not positive there is
// no gain and no serial work.
// o_in_stall is high while a measurement is in work, so a new measurement is
// accepted only once the previous one is through. A finished result sits in the
// output register; the next measurement may be accepted while it waits, but the
// block holds its final step until the receiver takes the previous result.
// Reset (synchronous, active low): registers to defaults, state zero, covariance
// init_var on the diagonal, both channels empty.
module kalman_filter_pos_vel_1d_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // measurement channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_position_meas,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_upd_pos,
    output logic signed [31:0] o_upd_vel,
    output logic signed [31:0] o_pred_pos,
    output logic signed [31:0] o_pred_vel,
    output logic [30:0]        o_var_pos,
    output logic signed [31:0] o_cov_cross,
    output logic [30:0]        o_var_vel,
    output logic               o_saturated,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam int W  = DATA_WIDTH;
    // working width for saturation checks: holds any 32-bit field and any W+1 sum
    localparam int EW = ((W > 32) ? W : 32) + 2;
    localparam logic signed [EW-1:0] LHI = (EW'(1) <<< (W - 1)) - EW'(1);
    localparam logic signed [EW-1:0] LLO = -LHI - EW'(1);
    localparam logic signed [EW-1:0] OHI = EW'(64'sh7fff_ffff);
    localparam logic signed [EW-1:0] OLO = -OHI - EW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_GO,
        S_WAIT,
        S_CLAMP1,
        S_PRED,
        S_CLAMP2,
        S_OUT
    } t_state;

    // --- saturation helpers: result is {clip, value} ---
    function automatic logic [W:0] sat_w(input logic signed [EW-1:0] v);
        logic [W:0] r;
        if (v > LHI) begin
            r = {1'b1, LHI[W-1:0]};
        end else if (v < LLO) begin
            r = {1'b1, LLO[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [W:0] fv(input logic [31:0] raw, input logic sgn);
        logic signed [EW-1:0] e;
        if (sgn) begin
            e = EW'($signed(raw));
        end else begin
            e = EW'({1'b0, raw[30:0]});
        end
        return sat_w(e);
    endfunction

    function automatic logic [W:0] add_s(input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b,
                                         input logic sub);
        logic signed [EW-1:0] e;
        if (sub) begin
            e = EW'(a) - EW'(b);
        end else begin
            e = EW'(a) + EW'(b);
        end
        return sat_w(e);
    endfunction

    function automatic logic [32:0] out_s(input logic signed [W-1:0] v);
        logic signed [EW-1:0] e;
        logic [32:0]          r;
        e = EW'(v);
        if (e > OHI) begin
            r = {1'b1, OHI[31:0]};
        end else if (e < OLO) begin
            r = {1'b1, OLO[31:0]};
        end else begin
            r = {1'b0, e[31:0]};
        end
        return r;
    endfunction

    function automatic logic [31:0] out_v(input logic signed [W-1:0] v);
        logic signed [EW-1:0] e;
        logic [31:0]          r;
        e = EW'(v);
        if (e > OHI) begin
            r = {1'b1, OHI[30:0]};
        end else if (e < EW'(0)) begin
            r = {1'b1, 31'd0};
        end else begin
            r = {1'b0, e[30:0]};
        end
        return r;
    endfunction

    // --- registers ---
    t_state               r_state;
    logic [30:0]          r_cfg_r;
    logic [30:0]          r_cfg_q00;
    logic [31:0]          r_cfg_q01;
    logic [30:0]          r_cfg_q11;
    logic [31:0]          r_cfg_u0;
    logic [31:0]          r_cfg_u1;
    logic [31:0]          r_z;
    logic signed [W-1:0]  r_est_pos;
    logic signed [W-1:0]  r_est_vel;
    logic signed [W-1:0]  r_cov_pp;
    logic signed [W-1:0]  r_cov_pv;
    logic signed [W-1:0]  r_cov_vv;
    logic signed [W-1:0]  r_s;
    logic signed [W-1:0]  r_y;
    logic signed [W-1:0]  r_k0;
    logic signed [W-1:0]  r_k1;
    logic signed [W-1:0]  r_upd_pos;
    logic signed [W-1:0]  r_upd_vel;
    logic                 r_clip;
    logic [2:0]           r_uidx;
    logic [3:0]           r_pidx;
    logic                 r_ustart;
    kf_pkg::t_op          r_uop;
    logic signed [W-1:0]  r_ua;
    logic signed [W-1:0]  r_ub;
    logic                 r_out_valid;
    logic signed [31:0]   r_o_upd_pos;
    logic signed [31:0]   r_o_upd_vel;
    logic signed [31:0]   r_o_pred_pos;
    logic signed [31:0]   r_o_pred_vel;
    logic [30:0]          r_o_var_pos;
    logic signed [31:0]   r_o_cov_cross;
    logic [30:0]          r_o_var_vel;
    logic                 r_o_sat;

    // --- serial unit ---
    kf_pkg::t_ureq        ureq;
    kf_pkg::t_uresp       uresp;
    logic signed [W-1:0]  ures;

    assign ureq.start = r_ustart;
    assign ureq.op    = r_uop;

    kf_serial_unit #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ureq),
        .i_a     (r_ua),
        .i_b     (r_ub),
        .o_resp  (uresp),
        .o_res   (ures)
    );

    // --- field conversions (clip into DATA_WIDTH range) ---
    logic [W:0] f_r, f_q00, f_q01, f_q11, f_u0, f_u1, f_z, f_init, f_rst_init;
    assign f_r        = fv({1'b0, r_cfg_r}, 1'b0);
    assign f_q00      = fv({1'b0, r_cfg_q00}, 1'b0);
    assign f_q01      = fv(r_cfg_q01, 1'b1);
    assign f_q11      = fv({1'b0, r_cfg_q11}, 1'b0);
    assign f_u0       = fv(r_cfg_u0, 1'b1);
    assign f_u1       = fv(r_cfg_u1, 1'b1);
    assign f_z        = fv(r_z, 1'b1);
    assign f_init     = fv({1'b0, i_cfg_data[30:0]}, 1'b0);
    assign f_rst_init = fv({1'b0, kf_pkg::INIT_VAR_RST}, 1'b0);

    // --- shared saturating adder operand select ---
    logic signed [W-1:0] sa, sb;
    logic                ssub;
    logic [W:0]          sres;
    logic [W:0]          yres;

    always_comb begin
        sa   = r_cov_pp;
        sb   = f_r[W-1:0];
        ssub = 1'b0;
        case (r_state)
            S_WAIT: begin
                sb = ures;
                case (r_uidx)
                    3'd2:    sa = r_est_pos;
                    3'd3:    sa = r_est_vel;
                    3'd4: begin
                        sa   = r_cov_pp;
                        ssub = 1'b1;
                    end
                    3'd5: begin
                        sa   = r_cov_vv;
                        ssub = 1'b1;
                    end
                    default: begin
                        sa   = r_cov_pv;
                        ssub = 1'b1;
                    end
                endcase
            end
            S_PRED: begin
                case (r_pidx)
                    4'd0: begin
                        sa = r_est_pos;
                        sb = r_est_vel;
                    end
                    4'd1: begin
                        sa = r_est_pos;
                        sb = f_u0[W-1:0];
                    end
                    4'd2: begin
                        sa = r_est_vel;
                        sb = f_u1[W-1:0];
                    end
                    4'd3, 4'd4: begin
                        sa = r_cov_pp;
                        sb = r_cov_pv;
                    end
                    4'd5: begin
                        sa = r_cov_pp;
                        sb = r_cov_vv;
                    end
                    4'd6: begin
                        sa = r_cov_pp;
                        sb = f_q00[W-1:0];
                    end
                    4'd7: begin
                        sa = r_cov_pv;
                        sb = r_cov_vv;
                    end
                    4'd8: begin
                        sa = r_cov_pv;
                        sb = f_q01[W-1:0];
                    end
                    default: begin
                        sa = r_cov_vv;
                        sb = f_q11[W-1:0];
                    end
                endcase
            end
            default: ;
        endcase
        sres = add_s(sa, sb, ssub);
        yres = add_s(f_z[W-1:0], r_est_pos, 1'b1);
    end

    // --- output conversion ---
    logic [32:0] c_upd_pos, c_upd_vel, c_pred_pos, c_pred_vel, c_cross;
    logic [31:0] c_var_pos, c_var_vel;
    assign c_upd_pos  = out_s(r_upd_pos);
    assign c_upd_vel  = out_s(r_upd_vel);
    assign c_pred_pos = out_s(r_est_pos);
    assign c_pred_vel = out_s(r_est_vel);
    assign c_cross    = out_s(r_cov_pv);
    assign c_var_pos  = out_v(r_cov_pp);
    assign c_var_vel  = out_v(r_cov_vv);

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // --- control and datapath ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ustart    <= 1'b0;
            r_clip      <= 1'b0;
            r_cfg_r     <= kf_pkg::MEAS_NOISE_RST;
            r_cfg_q00   <= '0;
            r_cfg_q01   <= '0;
            r_cfg_q11   <= '0;
            r_cfg_u0    <= '0;
            r_cfg_u1    <= '0;
            r_est_pos   <= '0;
            r_est_vel   <= '0;
            r_cov_pp    <= f_rst_init[W-1:0];
            r_cov_pv    <= '0;
            r_cov_vv    <= f_rst_init[W-1:0];
        end else begin
            // one-cycle start pulse per serial operation
            r_ustart <= (r_state == S_GO);
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kf_pkg::REG_MEAS_NOISE: r_cfg_r   <= i_cfg_data[30:0];
                    kf_pkg::REG_PROC_POS:   r_cfg_q00 <= i_cfg_data[30:0];
                    kf_pkg::REG_PROC_CROSS: r_cfg_q01 <= i_cfg_data;
                    kf_pkg::REG_PROC_VEL:   r_cfg_q11 <= i_cfg_data[30:0];
                    kf_pkg::REG_DRIVE_POS:  r_cfg_u0  <= i_cfg_data;
                    kf_pkg::REG_DRIVE_VEL:  r_cfg_u1  <= i_cfg_data;
                    kf_pkg::REG_INIT_VAR: begin
                        // restart: clear state, reload diagonal covariance
                        r_est_pos  <= '0;
                        r_est_vel  <= '0;
                        r_cov_pp   <= f_init[W-1:0];
                        r_cov_pv   <= '0;
                        r_cov_vv   <= f_init[W-1:0];
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_z     <= i_position_meas;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // S = P00 + R and innovation y = z - x0
                    r_s    <= sres[W-1:0];
                    r_y    <= yres[W-1:0];
                    r_uidx <= 3'd0;
                    r_pidx <= 4'd0;
                    if (!sres[W-1] && (sres[W-1:0] != '0)) begin
                        r_clip  <= f_r[W] | f_q00[W] | f_q01[W] | f_q11[W] | f_u0[W]
                                   | f_u1[W] | f_z[W] | sres[W] | yres[W];
                        r_state <= S_GO;
                    end else begin
                        // no gain: update leaves state alone, y clip not counted
                        r_clip  <= f_r[W] | f_q00[W] | f_q01[W] | f_q11[W] | f_u0[W]
                                   | f_u1[W] | f_z[W] | sres[W];
                        r_state <= S_PRED;
                    end
                end
                S_GO: begin
                    case (r_uidx)
                        3'd0: begin
                            r_uop <= kf_pkg::OP_DIV;
                            r_ua  <= r_cov_pp;
                            r_ub  <= r_s;
                        end
                        3'd1: begin
                            r_uop <= kf_pkg::OP_DIV;
                            r_ua  <= r_cov_pv;
                            r_ub  <= r_s;
                        end
                        3'd2: begin
                            r_uop <= kf_pkg::OP_MUL;
                            r_ua  <= r_k0;
                            r_ub  <= r_y;
                        end
                        3'd3: begin
                            r_uop <= kf_pkg::OP_MUL;
                            r_ua  <= r_k1;
                            r_ub  <= r_y;
                        end
                        3'd4: begin
                            r_uop <= kf_pkg::OP_MUL;
                            r_ua  <= r_k0;
                            r_ub  <= r_cov_pp;
                        end
                        3'd5: begin
                            // uses P01 before its own update
                            r_uop <= kf_pkg::OP_MUL;
                            r_ua  <= r_k1;
                            r_ub  <= r_cov_pv;
                        end
                        default: begin
                            r_uop <= kf_pkg::OP_MUL;
                            r_ua  <= r_k0;
                            r_ub  <= r_cov_pv;
                        end
                    endcase
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (uresp.done) begin
                        r_clip <= r_clip | uresp.clip | ((r_uidx > 3'd1) & sres[W]);
                        case (r_uidx)
                            3'd0:    r_k0      <= ures;
                            3'd1:    r_k1      <= ures;
                            3'd2:    r_est_pos <= sres[W-1:0];
                            3'd3:    r_est_vel <= sres[W-1:0];
                            3'd4:    r_cov_pp  <= sres[W-1:0];
                            3'd5:    r_cov_vv  <= sres[W-1:0];
                            default: r_cov_pv  <= sres[W-1:0];
                        endcase
                        if (r_uidx == 3'd6) begin
                            r_state <= S_CLAMP1;
                        end else begin
                            r_uidx  <= r_uidx + 3'd1;
                            r_state <= S_GO;
                        end
                    end
                end
                S_CLAMP1: begin
                    if (r_cov_pp[W-1]) begin
                        r_cov_pp <= '0;
                    end
                    if (r_cov_vv[W-1]) begin
                        r_cov_vv <= '0;
                    end
                    r_clip  <= r_clip | r_cov_pp[W-1] | r_cov_vv[W-1];
                    r_state <= S_PRED;
                end
                S_PRED: begin
                    r_clip <= r_clip | sres[W];
                    case (r_pidx)
                        4'd0: begin
                            r_upd_pos <= r_est_pos;
                            r_upd_vel <= r_est_vel;
                            r_est_pos <= sres[W-1:0];
                        end
                        4'd1:                      r_est_pos <= sres[W-1:0];
                        4'd2:                      r_est_vel <= sres[W-1:0];
                        4'd3, 4'd4, 4'd5, 4'd6:    r_cov_pp  <= sres[W-1:0];
                        4'd7, 4'd8:                r_cov_pv  <= sres[W-1:0];
                        default:                   r_cov_vv  <= sres[W-1:0];
                    endcase
                    if (r_pidx == 4'd9) begin
                        r_state <= S_CLAMP2;
                    end else begin
                        r_pidx <= r_pidx + 4'd1;
                    end
                end
                S_CLAMP2: begin
                    if (r_cov_pp[W-1]) begin
                        r_cov_pp <= '0;
                    end
                    if (r_cov_vv[W-1]) begin
                        r_cov_vv <= '0;
                    end
                    r_clip  <= r_clip | r_cov_pp[W-1] | r_cov_vv[W-1];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_upd_pos   <= c_upd_pos[31:0];
                        r_o_upd_vel   <= c_upd_vel[31:0];
                        r_o_pred_pos  <= c_pred_pos[31:0];
                        r_o_pred_vel  <= c_pred_vel[31:0];
                        r_o_var_pos   <= c_var_pos[30:0];
                        r_o_cov_cross <= c_cross[31:0];
                        r_o_var_vel   <= c_var_vel[30:0];
                        r_o_sat       <= r_clip | c_upd_pos[32] | c_upd_vel[32]
                                         | c_pred_pos[32] | c_pred_vel[32] | c_cross[32]
                                         | c_var_pos[31] | c_var_vel[31];
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_upd_pos   = r_o_upd_pos;
    assign o_upd_vel   = r_o_upd_vel;
    assign o_pred_pos  = r_o_pred_pos;
    assign o_pred_vel  = r_o_pred_vel;
    assign o_var_pos   = r_o_var_pos;
    assign o_cov_cross = r_o_cov_cross;
    assign o_var_vel   = r_o_var_vel;
    assign o_saturated = r_o_sat;

endmodule

/* rtl/core/kf_serial_unit.sv */
// Bit-serial signed fixed-point multiply (rounded) and divide (rounded).
module kf_serial_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kf_pkg::t_ureq                i_req,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output kf_pkg::t_uresp               o_resp,
    output logic signed [DATA_WIDTH-1:0] o_res
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F + 1;
    localparam int AW = (2 * W > NW) ? 2 * W : NW;
    localparam int MW = AW + 1;
    localparam int CW = $clog2(AW + 1);
    localparam logic [MW-1:0] UHI = (MW'(1) << (W - 1)) - MW'(1);

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIN
    } t_ustate;

    t_ustate          r_state;
    kf_pkg::t_op      r_op;
    logic             r_neg;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_acc;
    logic [AW-1:0]    r_sh;
    logic [W-1:0]     r_mp;
    logic [W-1:0]     r_div;
    logic [W-1:0]     r_rem;
    logic             r_done;
    logic             r_clip;
    logic [W-1:0]     r_res;

    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;
    logic [W:0]       rem_sh;
    logic             q_bit;
    logic [MW-1:0]    fin_mag;

    always_comb begin
        mag_a  = i_a[W-1] ? W'(-i_a) : W'(i_a);
        mag_b  = i_b[W-1] ? W'(-i_b) : W'(i_b);
        rem_sh = {r_rem, r_sh[NW-1]};
        q_bit  = (rem_sh >= {1'b0, r_div});
        if (r_op == kf_pkg::OP_MUL) begin
            fin_mag = (MW'(r_acc) + (MW'(1) << (F - 1))) >> F;
        end else begin
            fin_mag = MW'(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_clip  <= 1'b0;
        end else begin
            r_done <= (r_state == U_FIN);
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_neg   <= (i_req.op == kf_pkg::OP_MUL) ? (i_a[W-1] ^ i_b[W-1])
                                                                : i_a[W-1];
                        r_acc   <= '0;
                        r_rem   <= '0;
                        r_mp    <= mag_b;
                        r_div   <= i_b;
                        if (i_req.op == kf_pkg::OP_MUL) begin
                            r_sh  <= AW'(mag_a);
                            r_cnt <= CW'(W);
                        end else begin
                            r_sh  <= AW'((NW'(mag_a) << F) + NW'(i_b >> 1));
                            r_cnt <= CW'(NW);
                        end
                        r_state <= U_RUN;
                    end
                end
                U_RUN: begin
                    if (r_op == kf_pkg::OP_MUL) begin
                        if (r_mp[0]) begin
                            r_acc <= r_acc + r_sh;
                        end
                        r_sh <= r_sh << 1;
                        r_mp <= r_mp >> 1;
                    end else begin
                        r_rem <= q_bit ? W'(rem_sh - {1'b0, r_div}) : W'(rem_sh);
                        r_acc <= {r_acc[AW-2:0], q_bit};
                        r_sh  <= r_sh << 1;
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    // sign-magnitude back to two's complement, saturating
                    if (!r_neg) begin
                        if (fin_mag > UHI) begin
                            r_clip <= 1'b1;
                            r_res  <= UHI[W-1:0];
                        end else begin
                            r_clip <= 1'b0;
                            r_res  <= fin_mag[W-1:0];
                        end
                    end else begin
                        if (fin_mag > UHI + MW'(1)) begin
                            r_clip <= 1'b1;
                            r_res  <= {1'b1, {(W-1){1'b0}}};
                        end else begin
                            r_clip <= 1'b0;
                            r_res  <= W'(~fin_mag[W-1:0] + W'(1));
                        end
                    end
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_resp.done = r_done;
    assign o_resp.clip = r_clip;
    assign o_res       = r_res;

endmodule
